/* rtl/rcpb_pkg.sv */
// ----------------------------------------------------------------------------
// rcpb_pkg
// Shared types, constants and helpers for the random cycle builder.
// ----------------------------------------------------------------------------
package rcpb_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int CNT_W = 11;
	localparam int SPAN_W = 17;
	localparam int OFF_W = 26;
	localparam int SEED_W = 32;
	localparam int IDX_W = 10;

	localparam logic [0:0] FUNC_GEN = 1'b0;
	localparam logic [0:0] FUNC_QUERY = 1'b1;

	localparam logic [0:0] REG_NODE_COUNT = 1'b0;
	localparam logic [0:0] REG_NODE_SPAN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_DRAW,
		ST_DIV,
		ST_RD,
		ST_RDW,
		ST_WR,
		ST_LRD,
		ST_LRDW,
		ST_LWR,
		ST_QRD,
		ST_QMUL,
		ST_QOUT
	} state_t;

	// divider control and status
	typedef struct packed {
		logic        go;
		logic [31:0] dividend;
		logic [16:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] rem;
	} div_rsp_t;

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] a;
		logic [31:0] b;
		a = x ^ (x << 13);
		b = a ^ (a >> 17);
		return b ^ (b << 5);
	endfunction

endpackage

/* rtl/rcpb_ram.sv */
// ----------------------------------------------------------------------------
// rcpb_ram
// Single-port RAM, registered read.
// ----------------------------------------------------------------------------
module rcpb_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

/* rtl/rcpb_div.sv */
// ----------------------------------------------------------------------------
// rcpb_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcpb_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rcpb_pkg::div_req_t req,
	output rcpb_pkg::div_rsp_t rsp
);
	import rcpb_pkg::*;

	logic [31:0] num_q;
	logic [17:0] rem_q;
	logic [16:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] shifted;
	logic [17:0] diff;

	assign shifted = {rem_q[16:0], num_q[31]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= diff[17] ? shifted : diff;
		end
	end

	assign rsp = '{done: done_q, rem: rem_q[16:0]};

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q)) else $error("done without busy");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q) else $error("divider restarted while busy");
	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (rem_q[16:0] < den_q)) else $error("remainder too large");
`endif
endmodule

/* rtl/random_cycle_permutation_builder_top.sv */
// ----------------------------------------------------------------------------
// random_cycle_permutation_builder_top
// Builds a random single cycle over the nodes and answers successor queries.
// ----------------------------------------------------------------------------
//  channel | signals                               | handshake
//  item    | start func seed node_index            | start & !busy
//  result  | done successor_index successor_offset | done, one cycle
//          | generated index_error                 |
//  config  | cfg_valid cfg_index cfg_data          | cfg_valid & cfg_ready
//
//  Query: after acceptance, RAM read, multiply, then output with done; busy
//  drops the cycle after done.
//  Generate: fill count order entries, shuffle each position from count-1 down
//  to 1 (draw, remainder unit, two reads, two writes on one RAM port), link
//  count entries, then raise done.
//  Reset initialises control and the generator word; tables are not cleared.
//  The receiver cannot stall; busy is high from acceptance to done.
module random_cycle_permutation_builder_top #(
	parameter int MAX_NODES = rcpb_pkg::MAX_NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [rcpb_pkg::SEED_W-1:0]   seed,
	input  logic [rcpb_pkg::IDX_W-1:0]    node_index,
	output logic                          done,
	output logic [rcpb_pkg::IDX_W-1:0]    successor_index,
	output logic [rcpb_pkg::OFF_W-1:0]    successor_offset,
	output logic                          generated,
	output logic                          index_error,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [31:0]                   cfg_data
);
	import rcpb_pkg::*;

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] MAXC = CW'(MAX_NODES);

	state_t st_q, st_d;
	logic [CNT_W-1:0]  count_q;
	logic [SPAN_W-1:0] span_q;
	logic [31:0]       gen_q;
	logic [CW-1:0]     cnt_eff;
	logic [SPAN_W-1:0] span_eff;
	logic [CW-1:0]     ecnt_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     vi_q;
	logic [AW-1:0]     first_q;
	logic              func_q;
	logic [AW-1:0]     node_q;
	logic              err_q;
	logic [IDX_W-1:0]  succ_q;
	logic [42:0]       prod_q;

	logic          o_we, s_we;
	logic [AW-1:0] o_addr, s_addr, o_wd, s_wd, o_rd, s_rd;
	div_req_t      dreq;
	div_rsp_t      drsp;

	rcpb_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_order (
		.clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wd), .rdata(o_rd));
	rcpb_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_succ (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
	rcpb_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		if (count_q < CNT_W'(2))
			cnt_eff = CW'(2);
		else if ({{(32-CNT_W){1'b0}}, count_q} > 32'(MAX_NODES))
			cnt_eff = MAXC;
		else
			cnt_eff = CW'(count_q);
		if (span_q < SPAN_W'(8))
			span_eff = SPAN_W'(8);
		else if (span_q > SPAN_W'(65536))
			span_eff = SPAN_W'(65536);
		else
			span_eff = span_q;
	end

	assign cfg_ready = 1'b1;
	assign busy = (st_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1024);
			span_q <= SPAN_W'(8);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NODE_COUNT: count_q <= cfg_data[CNT_W-1:0];
				REG_NODE_SPAN:  span_q <= cfg_data[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			gen_q <= 32'd1;
		end else begin
			st_q <= st_d;
			if (start && !busy && func == FUNC_GEN)
				gen_q <= (seed == '0) ? 32'd1 : seed;
			else if (st_q == ST_DRAW)
				gen_q <= xorshift(gen_q);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				func_q <= func;
				node_q <= node_index[AW-1:0];
				err_q <= ({{(32-IDX_W){1'b0}}, node_index} >= 32'(cnt_eff));
				ecnt_q <= cnt_eff;
				i_q <= '0;
			end
			ST_FILL: begin
				if (i_q == AW'(ecnt_q - CW'(1)))
					i_q <= AW'(ecnt_q - CW'(1));
				else
					i_q <= i_q + AW'(1);
			end
			ST_DIV: if (drsp.done) j_q <= AW'(drsp.rem);
			ST_RDW: vi_q <= o_rd;
			ST_WR: begin
				if (i_q == AW'(1))
					i_q <= '0;
				else
					i_q <= i_q - AW'(1);
			end
			ST_LWR: begin
				// o_rd = order[i]; it becomes the source of the next link
				if (i_q == '0)
					first_q <= o_rd;
				vi_q <= o_rd;
				i_q <= i_q + AW'(1);
			end
			ST_QRD: ;
			ST_QMUL: begin
				succ_q <= IDX_W'(s_rd);
				prod_q <= {{(43-IDX_W){1'b0}}, IDX_W'(s_rd)} *
					{{(43-SPAN_W){1'b0}}, span_eff};
			end
			default: ;
		endcase
	end

	// ST_RD issues read of order[i], ST_RDW captures it and reads order[j]
	always_comb begin
		st_d = st_q;
		o_we = 1'b0;
		s_we = 1'b0;
		o_addr = i_q;
		s_addr = node_q;
		o_wd = i_q;
		s_wd = o_rd;
		dreq.go = 1'b0;
		dreq.dividend = gen_q;
		dreq.divisor = SPAN_W'(i_q) + SPAN_W'(1);
		done = 1'b0;
		generated = 1'b0;
		index_error = 1'b0;
		successor_index = '0;
		successor_offset = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (start)
					st_d = (func == FUNC_QUERY) ? ST_QRD : ST_FILL;
			end
			ST_FILL: begin
				o_we = 1'b1;
				if (i_q == AW'(ecnt_q - CW'(1)))
					st_d = ST_DRAW;
			end
			ST_DRAW: begin
				// start the remainder on the word drawn this cycle
				dreq.go = 1'b1;
				dreq.dividend = xorshift(gen_q);
				st_d = ST_DIV;
			end
			ST_DIV: begin
				if (drsp.done)
					st_d = ST_RD;
			end
			ST_RD: begin
				o_addr = i_q;
				st_d = ST_RDW;
			end
			ST_RDW: begin
				o_addr = j_q;
				st_d = ST_WR;
			end
			ST_WR: begin
				// order[j] arrives now: write it at i, then old order[i] at j
				o_we = 1'b1;
				o_addr = i_q;
				o_wd = o_rd;
				st_d = ST_LRD;
			end
			ST_LRD: begin
				o_we = 1'b1;
				o_addr = j_q;
				o_wd = vi_q;
				if (i_q == '0)
					st_d = ST_LRDW;
				else
					st_d = ST_DRAW;
			end
			ST_LRDW: begin
				o_addr = i_q;
				st_d = ST_LWR;
			end
			ST_LWR: begin
				// o_rd = order[i]; link order[i-1] -> order[i]
				if (i_q != '0) begin
					s_we = 1'b1;
					s_addr = vi_q;
					s_wd = o_rd;
				end
				if (CW'(i_q) == ecnt_q - CW'(1)) begin
					st_d = ST_QOUT;
				end else
					st_d = ST_LRDW;
			end
			ST_QRD: begin
				st_d = ST_QMUL;
			end
			ST_QMUL: st_d = ST_QOUT;
			ST_QOUT: begin
				if (func_q == FUNC_GEN) begin
					// close the cycle: last -> first
					s_we = 1'b1;
					s_addr = vi_q;
					s_wd = first_q;
					generated = 1'b1;
				end else if (err_q) begin
					index_error = 1'b1;
				end else begin
					successor_index = succ_q;
					successor_offset = (prod_q > 43'h3FFFFFF) ? '1 : prod_q[OFF_W-1:0];
				end
				done = 1'b1;
				st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

`ifndef SYNTH
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(generated && index_error)) else $error("conflicting flags");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |-> (successor_index == '0)) else $error("error index");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("not idle after done");
`endif
endmodule
